// File: sv/qau_pkg.sv
// quaternion arithmetic unit package: widths, codes, rounding and saturation helpers
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package qau_pkg;

  localparam int DW  = 32;
  localparam int FB  = 16;
  localparam int PW  = 2 * DW;
  localparam int RW  = PW - FB;
  localparam int SW  = RW + 2;
  localparam int XS  = SW + 1;
  localparam int QW  = DW;
  localparam int XW  = SW + QW;
  localparam int NP  = 16;
  localparam int NR  = 6;
  localparam int LAT = 4 + 3 + QW + 3;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_ROT  = 2'd1;
  localparam logic [1:0] OP_CONJ = 2'd2;
  localparam logic [1:0] OP_INV  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic [DW-1:0] W_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] W_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic [1:0]          op;
    logic                sat;
    logic [3:0][DW-1:0]  a;
    logic [3:0][DW-1:0]  b;
    logic [3:0][DW-1:0]  r;
    logic [SW-1:0]       n;
  } lane_t;

  // product rounded half up to FB fraction bits
  function automatic logic signed [RW-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p + $signed(PW'(1) << (FB - 1));
    return s[PW-1:FB];
  endfunction

  // clamp to the word range, flag in the top bit
  function automatic logic [DW:0] sat_w(input logic signed [XS-1:0] v);
    if (v > $signed({{(XS-DW+1){1'b0}}, {(DW-1){1'b1}}})) begin
      return {1'b1, W_MAX};
    end else if (v < $signed({{(XS-DW+1){1'b1}}, {(DW-1){1'b0}}})) begin
      return {1'b1, W_MIN};
    end
    return {1'b0, v[DW-1:0]};
  endfunction

endpackage
`default_nettype wire

// File: sv/qau_front.sv
// quaternion unit front end: input register, first products, sums, saturation
// depends on qau_pkg
`timescale 1ns / 1ps
`default_nettype none
module qau_front import qau_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                take,
  input  wire logic [1:0]          op,
  input  wire logic [3:0][DW-1:0]  a,
  input  wire logic [3:0][DW-1:0]  b,
  output logic                     vld,
  output lane_t                    lane
);

  logic v0, v1, v2;
  lane_t l0, l1, l2;
  logic signed [DW-1:0] ma [NP];
  logic signed [DW-1:0] mb [NP];
  logic signed [PW-1:0] p1 [NP];
  logic signed [RW-1:0] rp [NP];
  logic signed [SW-1:0] sm [4];
  logic signed [SW-1:0] s2 [4];
  lane_t lane_next;
  logic [DW:0] sv [4];
  logic [DW:0] cv [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      vld <= 1'b0;
    end else begin
      v0 <= take;
      v1 <= v0;
      v2 <= v1;
      vld <= v2;
    end
  end

  // operand selection for the sixteen multipliers
  always_comb begin
    ma[0]  = l0.b[0];  mb[0]  = l0.a[3];
    ma[1]  = l0.a[0];  mb[1]  = l0.b[3];
    ma[2]  = l0.a[1];  mb[2]  = l0.b[2];
    ma[3]  = l0.a[2];  mb[3]  = l0.b[1];
    ma[4]  = l0.b[1];  mb[4]  = l0.a[3];
    ma[5]  = l0.a[1];  mb[5]  = l0.b[3];
    ma[6]  = l0.a[2];  mb[6]  = l0.b[0];
    ma[7]  = l0.a[0];  mb[7]  = l0.b[2];
    ma[8]  = l0.b[2];  mb[8]  = l0.a[3];
    ma[9]  = l0.a[2];  mb[9]  = l0.b[3];
    ma[10] = l0.a[0];  mb[10] = l0.b[1];
    ma[11] = l0.a[1];  mb[11] = l0.b[0];
    ma[12] = l0.a[3];  mb[12] = l0.b[3];
    ma[13] = l0.a[0];  mb[13] = l0.b[0];
    ma[14] = l0.a[1];  mb[14] = l0.b[1];
    ma[15] = l0.a[2];  mb[15] = l0.b[2];
    if (l0.op == OP_ROT) begin
      mb[1] = '0;
      mb[5] = '0;
      mb[9] = '0;
    end
    if (l0.op == OP_INV) begin
      mb[12] = l0.a[3];
      mb[13] = l0.a[0];
      mb[14] = l0.a[1];
      mb[15] = l0.a[2];
    end
  end

  always_comb begin
    for (int j = 0; j < NP; j++) begin
      rp[j] = rnd(p1[j]);
    end
    for (int k = 0; k < 3; k++) begin
      sm[k] = SW'(rp[4*k]) + SW'(rp[4*k+1]) + SW'(rp[4*k+2]) - SW'(rp[4*k+3]);
    end
    if (l1.op == OP_INV) begin
      sm[3] = SW'(rp[12]) + SW'(rp[13]) + SW'(rp[14]) + SW'(rp[15]);
    end else begin
      sm[3] = SW'(rp[12]) - SW'(rp[13]) - SW'(rp[14]) - SW'(rp[15]);
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sv[k] = sat_w(XS'(s2[k]));
    end
    for (int k = 0; k < 3; k++) begin
      if (l2.a[k] == W_MIN) begin
        cv[k] = {1'b1, W_MAX};
      end else begin
        cv[k] = {1'b0, ~l2.a[k] + DW'(1)};
      end
    end
    lane_next = l2;
    lane_next.r = '0;
    lane_next.n = '0;
    lane_next.sat = 1'b0;
    case (l2.op)
      OP_MUL: begin
        for (int k = 0; k < 4; k++) begin
          lane_next.r[k] = sv[k][DW-1:0];
        end
        lane_next.sat = sv[0][DW] | sv[1][DW] | sv[2][DW] | sv[3][DW];
      end
      OP_ROT: begin
        for (int k = 0; k < 3; k++) begin
          lane_next.r[k] = sv[k][DW-1:0];
        end
        lane_next.sat = sv[0][DW] | sv[1][DW] | sv[2][DW];
      end
      OP_CONJ: begin
        for (int k = 0; k < 3; k++) begin
          lane_next.r[k] = cv[k][DW-1:0];
        end
        lane_next.r[3] = l2.a[3];
        lane_next.sat = cv[0][DW] | cv[1][DW] | cv[2][DW];
      end
      OP_INV: begin
        lane_next.n = s2[3];
      end
      default: begin
        lane_next.n = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    l0.op  <= op;
    l0.sat <= 1'b0;
    l0.a   <= a;
    l0.b   <= b;
    l0.r   <= '0;
    l0.n   <= '0;
    for (int j = 0; j < NP; j++) begin
      p1[j] <= ma[j] * mb[j];
    end
    l1 <= l0;
    for (int k = 0; k < 4; k++) begin
      s2[k] <= sm[k];
    end
    l2 <= l1;
    lane <= lane_next;
  end

endmodule
`default_nettype wire

// File: sv/qau_rotate.sv
// quaternion unit rotation back end: a x t products, doubling, final saturation
// depends on qau_pkg
`timescale 1ns / 1ps
`default_nettype none
module qau_rotate import qau_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   vld_in,
  input  lane_t       lane_in,
  output logic        vld,
  output lane_t       lane
);

  logic v4, v5;
  lane_t l4, l5;
  logic signed [DW-1:0] ma [NR];
  logic signed [DW-1:0] mb [NR];
  logic signed [PW-1:0] p4 [NR];
  logic signed [RW-1:0] rp [NR];
  logic signed [XS-1:0] u [3];
  logic signed [XS-1:0] wv [3];
  logic signed [XS-1:0] s5 [3];
  logic [DW:0] sv [3];
  lane_t lane_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      vld <= 1'b0;
    end else begin
      v4 <= vld_in;
      v5 <= v4;
      vld <= v5;
    end
  end

  always_comb begin
    ma[0] = lane_in.a[1];  mb[0] = lane_in.r[2];
    ma[1] = lane_in.a[2];  mb[1] = lane_in.r[1];
    ma[2] = lane_in.a[2];  mb[2] = lane_in.r[0];
    ma[3] = lane_in.a[0];  mb[3] = lane_in.r[2];
    ma[4] = lane_in.a[0];  mb[4] = lane_in.r[1];
    ma[5] = lane_in.a[1];  mb[5] = lane_in.r[0];
  end

  always_comb begin
    for (int j = 0; j < NR; j++) begin
      rp[j] = rnd(p4[j]);
    end
    for (int k = 0; k < 3; k++) begin
      u[k]  = XS'(rp[2*k]) - XS'(rp[2*k+1]);
      wv[k] = XS'($signed(l4.b[k])) + (u[k] <<< 1);
    end
  end

  always_comb begin
    lane_next = l5;
    for (int k = 0; k < 3; k++) begin
      sv[k] = sat_w(s5[k]);
    end
    if (l5.op == OP_ROT) begin
      for (int k = 0; k < 3; k++) begin
        lane_next.r[k] = sv[k][DW-1:0];
      end
      lane_next.sat = l5.sat | sv[0][DW] | sv[1][DW] | sv[2][DW];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NR; j++) begin
      p4[j] <= ma[j] * mb[j];
    end
    l4 <= lane_in;
    for (int k = 0; k < 3; k++) begin
      s5[k] <= wv[k];
    end
    l5 <= l4;
    lane <= lane_next;
  end

endmodule
`default_nettype wire

// File: sv/qau_divider.sv
// quaternion unit inverse: pipelined restoring divider, one quotient bit a stage
// depends on qau_pkg
`timescale 1ns / 1ps
`default_nettype none
module qau_divider import qau_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          vld_in,
  input  lane_t              lane_in,
  output logic               vld,
  output logic [3:0][DW-1:0] r,
  output logic [1:0]         status
);

  typedef struct packed {
    lane_t               l;
    logic [SW-1:0]       den;
    logic [3:0]          neg;
    logic [3:0]          ovf;
    logic                zero;
    logic [3:0][XW-1:0]  rem;
    logic [3:0][QW-1:0]  q;
  } dstage_t;

  logic    pv;
  dstage_t pd;
  logic    dv [QW+1];
  dstage_t ds [QW+1];
  dstage_t pd_next;
  dstage_t ds0_next;
  logic [3:0][DW-1:0] r_next;
  logic [1:0] status_next;
  logic [DW-1:0] mag;
  logic fl;

  // operand preparation
  always_comb begin
    pd_next = '0;
    pd_next.l = lane_in;
    pd_next.den = {lane_in.n[SW-2:0], 1'b0};
    pd_next.zero = (lane_in.n == '0);
    for (int k = 0; k < 4; k++) begin
      mag = lane_in.a[k][DW-1] ? (~lane_in.a[k] + DW'(1)) : lane_in.a[k];
      pd_next.rem[k] = XW'(SW'({mag, {(FB+1){1'b0}}}) + lane_in.n);
    end
    for (int k = 0; k < 3; k++) begin
      pd_next.neg[k] = !lane_in.a[k][DW-1] && (lane_in.a[k] != '0);
    end
    pd_next.neg[3] = lane_in.a[3][DW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
      dv[0] <= 1'b0;
    end else begin
      pv <= vld_in;
      dv[0] <= pv;
    end
  end

  // quotient overflow check
  always_comb begin
    ds0_next = pd;
    for (int k = 0; k < 4; k++) begin
      ds0_next.ovf[k] = pd.rem[k] >= (XW'(pd.den) << QW);
    end
  end

  always_ff @(posedge clk) begin
    pd <= pd_next;
    ds[0] <= ds0_next;
  end

  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int BI = QW - 1 - s;
    dstage_t nx;
    logic [XW-1:0] dsh;

    always_comb begin
      nx = ds[s];
      dsh = XW'(ds[s].den) << BI;
      for (int k = 0; k < 4; k++) begin
        if (ds[s].rem[k] >= dsh) begin
          nx.rem[k] = ds[s].rem[k] - dsh;
          nx.q[k][BI] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[s+1] <= 1'b0;
      end else begin
        dv[s+1] <= dv[s];
      end
    end

    always_ff @(posedge clk) begin
      ds[s+1] <= nx;
    end
  end

  // sign, saturation and status
  always_comb begin
    r_next = ds[QW].l.r;
    fl = ds[QW].l.sat;
    if (ds[QW].l.op == OP_INV) begin
      fl = 1'b0;
      r_next = '0;
      if (!ds[QW].zero) begin
        for (int k = 0; k < 4; k++) begin
          if (ds[QW].neg[k]) begin
            if (ds[QW].ovf[k] || (ds[QW].q[k][QW-1] && (|ds[QW].q[k][QW-2:0]))) begin
              r_next[k] = W_MIN;
              fl = 1'b1;
            end else begin
              r_next[k] = ~ds[QW].q[k] + DW'(1);
            end
          end else begin
            if (ds[QW].ovf[k] || ds[QW].q[k][QW-1]) begin
              r_next[k] = W_MAX;
              fl = 1'b1;
            end else begin
              r_next[k] = ds[QW].q[k];
            end
          end
        end
      end
    end
    if (ds[QW].l.op == OP_INV && ds[QW].zero) begin
      status_next = ST_ZERO;
    end else if (fl) begin
      status_next = ST_SAT;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    r <= r_next;
    status <= status_next;
  end

endmodule
`default_nettype wire

// File: sv/quaternion_arithmetic_unit.sv
// quaternion arithmetic unit top level: front end, rotation stage, divider
// depends on qau_pkg, qau_front, qau_rotate, qau_divider
//
// channel  | handshake     | payload
// request  | start / busy  | req_type, a_x a_y a_z a_w, b_x b_y b_z b_w
// result   | done (strobe) | r_x r_y r_z r_w, status
//
// one item a cycle while busy is low; each result passes the product stages and the
// 32-stage quotient pipeline of the inverse on its way from the request to done
// busy is high only during reset; the pipeline never stalls
// done is high for one cycle per result, the receiver cannot hold it off
// synchronous reset clears all valid bits
`timescale 1ns / 1ps
`default_nettype none
module quaternion_arithmetic_unit import qau_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           req_type,
  input  wire logic signed [DW-1:0] a_x,
  input  wire logic signed [DW-1:0] a_y,
  input  wire logic signed [DW-1:0] a_z,
  input  wire logic signed [DW-1:0] a_w,
  input  wire logic signed [DW-1:0] b_x,
  input  wire logic signed [DW-1:0] b_y,
  input  wire logic signed [DW-1:0] b_z,
  input  wire logic signed [DW-1:0] b_w,
  output logic                      done,
  output logic signed [DW-1:0]      r_x,
  output logic signed [DW-1:0]      r_y,
  output logic signed [DW-1:0]      r_z,
  output logic signed [DW-1:0]      r_w,
  output logic [1:0]                status
);

  logic fv, rv;
  lane_t fl, rl;
  logic [3:0][DW-1:0] av, bv, rr;

  assign busy = rst;
  assign av = {a_w, a_z, a_y, a_x};
  assign bv = {b_w, b_z, b_y, b_x};

  qau_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (start && !busy),
    .op   (req_type),
    .a    (av),
    .b    (bv),
    .vld  (fv),
    .lane (fl)
  );

  qau_rotate u_rotate (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (fv),
    .lane_in (fl),
    .vld     (rv),
    .lane    (rl)
  );

  qau_divider u_divider (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (rv),
    .lane_in (rl),
    .vld     (done),
    .r       (rr),
    .status  (status)
  );

  assign r_x = rr[0];
  assign r_y = rr[1];
  assign r_z = rr[2];
  assign r_w = rr[3];

endmodule
`default_nettype wire

// File: sv/qau_checker.sv
// port-level checks for the quaternion arithmetic unit, bound to the top level
// depends on qau_pkg and quaternion_arithmetic_unit
`timescale 1ns / 1ps
`default_nettype none
module qau_checker import qau_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic [1:0]           req_type,
  input wire logic                 done,
  input wire logic signed [DW-1:0] r_x,
  input wire logic signed [DW-1:0] r_y,
  input wire logic signed [DW-1:0] r_z,
  input wire logic signed [DW-1:0] r_w,
  input wire logic [1:0]           status
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without an item taken at the pipeline latency");

  a_zero_inv: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_ZERO) |-> (r_x == 0 && r_y == 0 && r_z == 0 && r_w == 0))
    else $error("zero-length inverse with nonzero result");

  a_rot_w: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && !busy && req_type == OP_ROT, LAT)) |-> (r_w == 0))
    else $error("rotate result with nonzero scalar");

endmodule

bind quaternion_arithmetic_unit qau_checker u_chk (.*);
`default_nettype wire
